FILE: rtl/tlfd_pkg.sv
// Package for the two-length frame deframer.
// Holds header sizes and result kind codes shared by the core and its checker.
// No dependencies.
package tlfd_pkg;

  // Header layout: two big-endian 32-bit lengths
  localparam int unsigned LenBytes = 4;
  localparam int unsigned HdrBytes = 2 * LenBytes;
  localparam int unsigned LenWidth = 8 * LenBytes;
  localparam int unsigned HdrCntWidth = $clog2(HdrBytes);

  // Result kind codes on byte_kind
  typedef enum logic [1:0] {
    KindAuthor = 2'd0,
    KindData   = 2'd1,
    KindEmpty  = 2'd2
  } kind_e;

endpackage

FILE: rtl/two_length_frame_deframer_core.sv
// Two-length frame deframer core: header parse, field countdown, result register.
// Depends on tlfd_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / stream_byte_i) carries the raw
//   framed stream, one byte per request. Each frame is an 8-byte header
//   (big-endian 32-bit author length, then big-endian 32-bit data length),
//   then the author bytes, then the data bytes.
//   Output channel (out_valid_o / out_stall_i / payload fields) carries one
//   request per payload byte, tagged author or data, with field_last and
//   frame_last. A frame with both lengths zero gives a single empty-frame
//   marker (byte_kind 2, payload 0, frame_last 1). Header bytes give nothing.
//   Results are registered: a result appears in the cycle after its byte is accepted.
//   Throughput: one byte per cycle while in_stall_o is low; the per-byte work is
//   a 32-bit countdown and compare that completes in the accept cycle.
//   The result register frees up in the cycle it is taken, so a new byte is
//   accepted while a finished result is leaving. While the receiver stalls a
//   held result, in_stall_o is high and the result holds still.
//   Reset (rst_ni low, asynchronous) returns the parser to the header phase
//   with counts cleared and drops any held result.
module two_length_frame_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] stream_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic [1:0] byte_kind_o,
  output logic       field_last_o,
  output logic       frame_last_o
);

  typedef enum logic [1:0] {
    PhHeader = 2'd0,
    PhAuthor = 2'd1,
    PhData   = 2'd2
  } phase_e;

  localparam int unsigned LW = tlfd_pkg::LenWidth;
  localparam int unsigned CW = tlfd_pkg::HdrCntWidth;

  phase_e            phase_q, phase_d;
  logic [CW-1:0]     hdr_cnt_q, hdr_cnt_d;
  logic [LW-1:0]     author_len_q, author_len_d;
  logic [LW-1:0]     data_len_q, data_len_d;
  logic [LW-1:0]     bytes_left_q, bytes_left_d;

  logic              out_valid_q, out_valid_d;
  logic [7:0]        payload_q, payload_d;
  tlfd_pkg::kind_e   kind_q, kind_d;
  logic              field_last_q, field_last_d;
  logic              frame_last_q, frame_last_d;

  logic              in_acc;
  logic              out_acc;
  logic              res_gen;
  logic              field_end;

  // Handshake: stall only while a held result is itself stalled
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_acc    = out_valid_q & ~out_stall_i;
  assign field_end  = (bytes_left_q <= LW'(1));

  // Parser next state and result generation
  always_comb begin
    phase_d      = phase_q;
    hdr_cnt_d    = hdr_cnt_q;
    author_len_d = author_len_q;
    data_len_d   = data_len_q;
    bytes_left_d = bytes_left_q;
    res_gen      = 1'b0;
    payload_d    = stream_byte_i;
    kind_d       = tlfd_pkg::KindAuthor;
    field_last_d = 1'b0;
    frame_last_d = 1'b0;
    if (in_acc) begin
      case (phase_q)
        PhAuthor: begin
          res_gen = 1'b1;
          kind_d  = tlfd_pkg::KindAuthor;
          if (field_end) begin
            field_last_d = 1'b1;
            if (data_len_q != '0) begin
              phase_d      = PhData;
              bytes_left_d = data_len_q;
            end else begin
              phase_d      = PhHeader;
              bytes_left_d = '0;
              frame_last_d = 1'b1;
            end
          end else begin
            bytes_left_d = bytes_left_q - LW'(1);
          end
        end
        PhData: begin
          res_gen = 1'b1;
          kind_d  = tlfd_pkg::KindData;
          if (field_end) begin
            phase_d      = PhHeader;
            bytes_left_d = '0;
            field_last_d = 1'b1;
            frame_last_d = 1'b1;
          end else begin
            bytes_left_d = bytes_left_q - LW'(1);
          end
        end
        default: begin
          // Header phase, also taken for the unused phase code
          phase_d = PhHeader;
          if (hdr_cnt_q < CW'(tlfd_pkg::LenBytes)) begin
            author_len_d = {author_len_q[LW-9:0], stream_byte_i};
          end else begin
            data_len_d = {data_len_q[LW-9:0], stream_byte_i};
          end
          if (hdr_cnt_q != CW'(tlfd_pkg::HdrBytes - 1)) begin
            hdr_cnt_d = hdr_cnt_q + CW'(1);
          end else begin
            hdr_cnt_d = '0;
            if (author_len_d != '0) begin
              phase_d      = PhAuthor;
              bytes_left_d = author_len_d;
            end else if (data_len_d != '0) begin
              phase_d      = PhData;
              bytes_left_d = data_len_d;
            end else begin
              // Both lengths zero: empty-frame marker
              bytes_left_d = '0;
              res_gen      = 1'b1;
              payload_d    = 8'd0;
              kind_d       = tlfd_pkg::KindEmpty;
              frame_last_d = 1'b1;
            end
          end
        end
      endcase
    end
  end

  // Result register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_acc) out_valid_d = 1'b0;
    if (res_gen) out_valid_d = 1'b1;
  end

  // Parser state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHeader;
      hdr_cnt_q    <= '0;
      author_len_q <= '0;
      data_len_q   <= '0;
      bytes_left_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      hdr_cnt_q    <= hdr_cnt_d;
      author_len_q <= author_len_d;
      data_len_q   <= data_len_d;
      bytes_left_q <= bytes_left_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload, loaded only with a new result
  always_ff @(posedge clk_i) begin
    if (res_gen) begin
      payload_q    <= payload_d;
      kind_q       <= kind_d;
      field_last_q <= field_last_d;
      frame_last_q <= frame_last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = payload_q;
  assign byte_kind_o    = kind_q;
  assign field_last_o   = field_last_q;
  assign frame_last_o   = frame_last_q;

endmodule

FILE: rtl/tlfd_checker.sv
// Port-level checker for the two-length frame deframer core, with its bind.
// Depends on tlfd_pkg and two_length_frame_deframer_core.
module tlfd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] payload_byte_o,
  input logic [1:0] byte_kind_o,
  input logic       field_last_o,
  input logic       frame_last_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(payload_byte_o) &&
      $stable(byte_kind_o) && $stable(field_last_o) && $stable(frame_last_o))
    else $error("stalled result changed");

  // Empty-frame marker has a fixed form
  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_kind_o == tlfd_pkg::KindEmpty |->
      payload_byte_o == 8'd0 && !field_last_o && frame_last_o)
    else $error("malformed empty-frame marker");

  // Frame end on an author byte must also end the author field
  a_author_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_kind_o == tlfd_pkg::KindAuthor && frame_last_o |->
      field_last_o)
    else $error("author frame end without field end");

  // Data field end is always frame end, and no undefined kind appears
  a_data_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> byte_kind_o != 2'd3 &&
      (byte_kind_o != tlfd_pkg::KindData || field_last_o == frame_last_o))
    else $error("bad data byte flags or kind");

endmodule

bind two_length_frame_deframer_core tlfd_checker u_tlfd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .payload_byte_o (payload_byte_o),
  .byte_kind_o    (byte_kind_o),
  .field_last_o   (field_last_o),
  .frame_last_o   (frame_last_o)
);

FILE: tb/two_length_frame_deframer_core_tb.sv
// Testbench for two_length_frame_deframer_core: feeds framed byte streams and checks
// every payload result against a behavioral deframer, with random idling on both sides.
// Depends on tlfd_pkg and the core RTL.
module two_length_frame_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 2000;
  localparam int CalmTail = 220;

  typedef enum logic [1:0] {
    PhHeader = 2'd0,
    PhAuthor = 2'd1,
    PhData   = 2'd2
  } parse_phase_e;

  typedef struct packed {
    logic [7:0]      pbyte;
    tlfd_pkg::kind_e kind;
    logic            field_last;
    logic            frame_last;
  } payload_result_t;

  typedef struct {
    logic [7:0] b;
    bit         drain;
    bit         calm;
  } stream_req_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] stream_byte = 8'd0;
  logic       out_stall = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] payload_byte_o;
  logic [1:0] byte_kind_o;
  logic       field_last_o;
  logic       frame_last_o;

  stream_req_t     byte_q[$];
  payload_result_t result_q[$];
  int              send_gap = 0;
  int              stall_left = 0;
  bit              calm = 1'b0;
  int              idle_cycles = 0;
  int              mismatches = 0;

  // Deframer state mirrored by the checker
  parse_phase_e ph = PhHeader;
  logic [2:0]   hdr_cnt = '0;
  logic [31:0]  auth_len = '0;
  logic [31:0]  data_len = '0;
  logic [31:0]  remain = '0;

  two_length_frame_deframer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .stream_byte_i  (stream_byte),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .payload_byte_o (payload_byte_o),
    .byte_kind_o    (byte_kind_o),
    .field_last_o   (field_last_o),
    .frame_last_o   (frame_last_o)
  );

  always #4 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Advance the parser by one stream byte; emit is set when a result comes out
  task automatic deframe_byte(input logic [7:0] b, output bit emit, output payload_result_t r);
    emit = 1'b0;
    r = '0;
    case (ph)
      PhAuthor: begin
        emit = 1'b1;
        if (remain <= 32'd1) begin
          r = '{pbyte: b, kind: tlfd_pkg::KindAuthor, field_last: 1'b1,
                frame_last: data_len == 0};
          if (data_len != 0) begin
            ph = PhData;
            remain = data_len;
          end else begin
            ph = PhHeader;
            remain = '0;
          end
        end else begin
          remain--;
          r = '{pbyte: b, kind: tlfd_pkg::KindAuthor, field_last: 1'b0, frame_last: 1'b0};
        end
      end
      PhData: begin
        emit = 1'b1;
        if (remain <= 32'd1) begin
          ph = PhHeader;
          remain = '0;
          r = '{pbyte: b, kind: tlfd_pkg::KindData, field_last: 1'b1, frame_last: 1'b1};
        end else begin
          remain--;
          r = '{pbyte: b, kind: tlfd_pkg::KindData, field_last: 1'b0, frame_last: 1'b0};
        end
      end
      default: begin
        // header byte; unused phase code falls back here too
        ph = PhHeader;
        if (hdr_cnt < tlfd_pkg::LenBytes) auth_len = {auth_len[23:0], b};
        else data_len = {data_len[23:0], b};
        if (hdr_cnt != 3'(tlfd_pkg::HdrBytes - 1)) begin
          hdr_cnt++;
        end else begin
          hdr_cnt = '0;
          if (auth_len != 0) begin
            ph = PhAuthor;
            remain = auth_len;
          end else if (data_len != 0) begin
            ph = PhData;
            remain = data_len;
          end else begin
            remain = '0;
            emit = 1'b1;
            r = '{pbyte: 8'd0, kind: tlfd_pkg::KindEmpty, field_last: 1'b0,
                  frame_last: 1'b1};
          end
        end
      end
    endcase
  endtask

  // Header plus body bytes; fill < 0 gives random payload
  task automatic add_frame(input logic [31:0] alen, input logic [31:0] dlen, input int body,
                           input int fill, input bit drain);
    stream_req_t s;
    for (int i = 0; i < 8; i++) begin
      s.b = (i < 4) ? alen[8*(3-i) +: 8] : dlen[8*(7-i) +: 8];
      s.drain = drain && (i == 0);
      s.calm = 1'b0;
      byte_q.push_back(s);
    end
    for (int i = 0; i < body; i++) begin
      s.b = (fill < 0) ? 8'($urandom) : 8'(fill);
      s.drain = 1'b0;
      s.calm = 1'b0;
      byte_q.push_back(s);
    end
  endtask

  // Mostly short fields, some empty, a few crossing into the second length byte
  function automatic logic [31:0] pick_len();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 20) return 32'd0;
    if (sel < 85) return 32'($urandom_range(1, 8));
    if (sel < 97) return 32'($urandom_range(9, 40));
    return 32'($urandom_range(256, 270));
  endfunction

  // Driver: presents queued stream bytes, holds them while stalled
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall_o) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (byte_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (byte_q[0].drain && (in_valid || out_valid_o || result_q.size() != 0)) begin
        // hold off until every outstanding result has been taken
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        send_gap <= $urandom_range(0, 13);
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        stream_byte <= byte_q[0].b;
        calm <= byte_q[0].calm;
        void'(byte_q.pop_front());
      end
    end
  end

  // Monitor: checks results in order, predicts from accepted bytes, drives stall
  always @(posedge clk_i) begin
    payload_result_t got;
    payload_result_t want;
    payload_result_t next_res;
    bit              emit;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        got = '{pbyte: payload_byte_o, kind: tlfd_pkg::kind_e'(byte_kind_o),
                field_last: field_last_o, frame_last: frame_last_o};
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing expected", got));
        end else begin
          want = result_q.pop_front();
          if (got.pbyte !== want.pbyte)
            report_mismatch($sformatf("payload_byte %h, expected %h", got.pbyte, want.pbyte));
          if (got.kind !== want.kind)
            report_mismatch($sformatf("byte_kind %0d, expected %0d", got.kind, want.kind));
          if (got.field_last !== want.field_last)
            report_mismatch($sformatf("field_last %b, expected %b",
                                      got.field_last, want.field_last));
          if (got.frame_last !== want.frame_last)
            report_mismatch($sformatf("frame_last %b, expected %b",
                                      got.frame_last, want.frame_last));
        end
      end
      if (in_valid && !in_stall_o) begin
        deframe_byte(stream_byte, emit, next_res);
        if (emit) result_q.push_back(next_res);
      end
      idle_cycles <= ((out_valid_o && !out_stall) || (in_valid && !in_stall_o)) ?
                     0 : idle_cycles + 1;
      // receiver stall bursts
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [31:0] alen;
    logic [31:0] dlen;
    bit          first;
    // empty frame, author-only frame with 0xFF, data-only frame with 0x00
    add_frame(32'd0, 32'd0, 0, -1, 1'b0);
    add_frame(32'd1, 32'd0, 1, 8'hFF, 1'b0);
    add_frame(32'd0, 32'd1, 1, 8'h00, 1'b0);
    first = 1'b1;
    while (byte_q.size() < 1480) begin
      alen = pick_len();
      dlen = pick_len();
      add_frame(alen, dlen, int'(alen + dlen), -1, first || $urandom_range(0, 15) == 0);
      first = 1'b0;
    end
    // full-scale lengths; the run stops partway into this frame
    add_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24, -1, 1'b0);
    for (int i = byte_q.size() - CalmTail; i < byte_q.size(); i++) byte_q[i].calm = 1'b1;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (!(byte_q.size() == 0 && !in_valid && result_q.size() == 0) &&
           idle_cycles < IdleLimit);

    if (idle_cycles >= IdleLimit) begin
      $display("two_length_frame_deframer_core verification failed");
    end else begin
      repeat (8) @(negedge clk_i);
      if (result_q.size() != 0) report_mismatch("expected results never arrived");
      if (mismatches == 0) begin
        $display("two_length_frame_deframer_core verification clean");
      end else begin
        $display("two_length_frame_deframer_core verification failed");
      end
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tlfd_pkg.sv
rtl/two_length_frame_deframer_core.sv
rtl/tlfd_checker.sv
tb/two_length_frame_deframer_core_tb.sv
